>>> rtl/core/acm_pkg.sv
`default_nettype none
// Package for the multi-pattern matcher: request and result types,
// opcode and status codes, controller/datapath command and status types.
// No dependencies.
package acm_pkg;

    localparam int ALPHABET  = 70;
    localparam int SYM_W     = 7;
    localparam int CNT_OUT_W = 16;

    localparam logic [6:0] OTHER_SYM = 7'd69;
    localparam logic [6:0] LAST_SYM  = 7'd69;

    localparam logic [2:0] OPC_INSERT = 3'd0;
    localparam logic [2:0] OPC_EXACT  = 3'd1;
    localparam logic [2:0] OPC_PREFIX = 3'd2;
    localparam logic [2:0] OPC_BUILD  = 3'd3;
    localparam logic [2:0] OPC_SCAN   = 3'd4;
    localparam logic [2:0] OPC_CLEAR  = 3'd5;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_CONSUMED = 2'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] symbol;
        logic       first;
        logic       last;
    } req_t;

    typedef struct packed {
        logic [15:0] count;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLR_START,
        CMD_CLR_STEP,
        CMD_GOTO_RD,
        CMD_INS_UPD,
        CMD_INS_WR,
        CMD_SRCH_UPD,
        CMD_SRCH_RES,
        CMD_SCAN_UPD,
        CMD_SCAN_STEP,
        CMD_SCAN_RES,
        CMD_BLD_START,
        CMD_FZ_STEP,
        CMD_ROOT_RD,
        CMD_ROOT_PUSH,
        CMD_Q_RD,
        CMD_U_LATCH,
        CMD_F_RD,
        CMD_E_RD,
        CMD_E_UPD,
        CMD_DONE
    } dp_op_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic missed;
        logic head_lt_tail;
        logic sym_last;
        logic idx_node_last;
        logic idx_clr_last;
        logic chain_stop;
    } dp_status_t;

    function automatic logic [6:0] sym_of(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b inside {[8'h61:8'h7A]}) begin
                d = b - 8'h61;
            end else if (b inside {[8'h41:8'h5A]}) begin
                d = b - 8'h41 + 8'd26;
            end else if (b inside {[8'h30:8'h39]}) begin
                d = b - 8'h30 + 8'd52;
            end else begin
                d = {1'b0, OTHER_SYM};
            end
            return d[6:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/acm_ctrl.sv
`default_nettype none
// Controller state machine of the multi-pattern matcher.
// Issues one datapath command per cycle; depends on acm_pkg.
module acm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [2:0]          opcode,
    input  wire acm_pkg::dp_status_t stat,
    output logic                     busy,
    output acm_pkg::dp_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR_START,
        S_CLR_STEP,
        S_INS_RD,
        S_INS_UPD,
        S_INS_WR,
        S_SRCH_RD,
        S_SRCH_UPD,
        S_SRCH_RES,
        S_SCAN_RD,
        S_SCAN_UPD,
        S_SCAN_STEP,
        S_SCAN_RES,
        S_BLD_START,
        S_FZ_STEP,
        S_ROOT_RD,
        S_ROOT_PUSH,
        S_Q_RD,
        S_U_LATCH,
        S_F_RD,
        S_E_RD,
        S_E_UPD,
        S_DONE
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.accept = start && (state_reg == S_IDLE);
        case (state_reg)
            S_CLR_START: cmd.op = acm_pkg::CMD_CLR_START;
            S_CLR_STEP:  cmd.op = acm_pkg::CMD_CLR_STEP;
            S_INS_RD:    cmd.op = acm_pkg::CMD_GOTO_RD;
            S_INS_UPD:   cmd.op = acm_pkg::CMD_INS_UPD;
            S_INS_WR:    cmd.op = acm_pkg::CMD_INS_WR;
            S_SRCH_RD:   cmd.op = acm_pkg::CMD_GOTO_RD;
            S_SRCH_UPD:  cmd.op = acm_pkg::CMD_SRCH_UPD;
            S_SRCH_RES:  cmd.op = acm_pkg::CMD_SRCH_RES;
            S_SCAN_RD:   cmd.op = acm_pkg::CMD_GOTO_RD;
            S_SCAN_UPD:  cmd.op = acm_pkg::CMD_SCAN_UPD;
            S_SCAN_STEP: cmd.op = acm_pkg::CMD_SCAN_STEP;
            S_SCAN_RES:  cmd.op = acm_pkg::CMD_SCAN_RES;
            S_BLD_START: cmd.op = acm_pkg::CMD_BLD_START;
            S_FZ_STEP:   cmd.op = acm_pkg::CMD_FZ_STEP;
            S_ROOT_RD:   cmd.op = acm_pkg::CMD_ROOT_RD;
            S_ROOT_PUSH: cmd.op = acm_pkg::CMD_ROOT_PUSH;
            S_Q_RD:      cmd.op = acm_pkg::CMD_Q_RD;
            S_U_LATCH:   cmd.op = acm_pkg::CMD_U_LATCH;
            S_F_RD:      cmd.op = acm_pkg::CMD_F_RD;
            S_E_RD:      cmd.op = acm_pkg::CMD_E_RD;
            S_E_UPD:     cmd.op = acm_pkg::CMD_E_UPD;
            S_DONE:      cmd.op = acm_pkg::CMD_DONE;
            default:     cmd.op = acm_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLR_START;
        end else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        case (opcode)
                            acm_pkg::OPC_INSERT: state_reg <= S_INS_RD;
                            acm_pkg::OPC_EXACT:  state_reg <= S_SRCH_RD;
                            acm_pkg::OPC_PREFIX: state_reg <= S_SRCH_RD;
                            acm_pkg::OPC_BUILD:  state_reg <= S_BLD_START;
                            acm_pkg::OPC_SCAN:   state_reg <= S_SCAN_RD;
                            acm_pkg::OPC_CLEAR:  state_reg <= S_CLR_START;
                            default:             state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CLR_START: state_reg <= S_CLR_STEP;
                S_CLR_STEP:  state_reg <= stat.idx_clr_last ? S_DONE : S_CLR_STEP;
                S_INS_RD:    state_reg <= stat.missed ? S_INS_WR : S_INS_UPD;
                S_INS_UPD:   state_reg <= S_INS_WR;
                S_INS_WR:    state_reg <= S_IDLE;
                S_SRCH_RD:   state_reg <= S_SRCH_UPD;
                S_SRCH_UPD:  state_reg <= S_SRCH_RES;
                S_SRCH_RES:  state_reg <= S_IDLE;
                S_SCAN_RD:   state_reg <= S_SCAN_UPD;
                S_SCAN_UPD:  state_reg <= S_SCAN_STEP;
                S_SCAN_STEP: state_reg <= stat.chain_stop ? S_SCAN_RES : S_SCAN_STEP;
                S_SCAN_RES:  state_reg <= S_IDLE;
                S_BLD_START: state_reg <= S_FZ_STEP;
                S_FZ_STEP:   state_reg <= stat.idx_node_last ? S_ROOT_RD : S_FZ_STEP;
                S_ROOT_RD:   state_reg <= S_ROOT_PUSH;
                S_ROOT_PUSH: state_reg <= stat.sym_last ? S_Q_RD : S_ROOT_RD;
                S_Q_RD:      state_reg <= stat.head_lt_tail ? S_U_LATCH : S_DONE;
                S_U_LATCH:   state_reg <= S_F_RD;
                S_F_RD:      state_reg <= S_E_RD;
                S_E_RD:      state_reg <= S_E_UPD;
                S_E_UPD:     state_reg <= stat.sym_last ? S_Q_RD : S_F_RD;
                S_DONE:      state_reg <= S_IDLE;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/acm_dp.sv
`default_nettype none
// Datapath of the multi-pattern matcher: trie, count, link and queue
// memories with the cursor, counters and result register; depends on acm_pkg.
module acm_dp #(
    parameter int NODES      = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire acm_pkg::dp_cmd_t    cmd,
    input  wire acm_pkg::req_t       req,
    output acm_pkg::dp_status_t      stat,
    output logic                     rsp_valid,
    output acm_pkg::rsp_t            rsp
);

    localparam int NB     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int GDEPTH = NODES * acm_pkg::ALPHABET;
    localparam int GA     = $clog2(GDEPTH);
    localparam int CB     = COUNT_BITS;

    logic [NB-1:0] goto_mem  [GDEPTH];
    logic [CB:0]   endc_mem  [NODES];
    logic [CB-1:0] pref_mem  [NODES];
    logic [NB-1:0] fail_mem  [NODES];
    logic [NB-1:0] queue_mem [NODES];

    logic [NB-1:0] goto_rd_a, goto_rd_b, fail_rd, queue_rd;
    logic [CB:0]   endc_rd;
    logic [CB-1:0] pref_rd;

    logic [2:0]    op_reg;
    logic [6:0]    sym_reg;
    logic          last_reg;
    logic [NB-1:0] cursor_reg, j_reg, u_reg;
    logic          missed_reg, byp_reg;
    logic [NB:0]   nodes_used_reg, head_reg, tail_reg;
    logic [CB-1:0] total_reg;
    logic [6:0]    bsym_reg;
    logic [GA-1:0] idx_reg;
    logic          rsp_valid_reg;
    acm_pkg::rsp_t rsp_reg;

    logic          goto_we, endc_we, pref_we, fail_we, queue_we;
    logic [GA-1:0] goto_waddr, addr_a, addr_b;
    logic [NB-1:0] goto_wdata, fail_waddr, fail_wdata, cnt_waddr, cnt_raddr, fail_raddr;
    logic [CB:0]   endc_wdata;
    logic [CB-1:0] pref_wdata;
    logic [NB-1:0] node_a;
    logic [6:0]    sym_a;
    logic          ins_new, full, push_ok, stop, idx_in_nodes;
    logic [NB-1:0] nxt;

    function automatic logic [GA-1:0] gaddr(input logic [NB-1:0] n, input logic [6:0] s);
        return GA'(n) * GA'(acm_pkg::ALPHABET) + GA'(s);
    endfunction

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[CB] ? {CB{1'b1}} : s[CB-1:0];
        end
    endfunction

    function automatic logic [15:0] sat16(input logic [CB-1:0] a);
        logic [32:0] w;
        begin
            w = 33'(a);
            return (w > 33'd65535) ? 16'hFFFF : w[15:0];
        end
    endfunction

    assign ins_new      = (goto_rd_a == '0);
    assign full         = (nodes_used_reg >= (NB+1)'(NODES));
    assign nxt          = ins_new ? nodes_used_reg[NB-1:0] : goto_rd_a;
    assign push_ok      = (tail_reg < (NB+1)'(NODES));
    assign stop         = (j_reg == '0) || endc_rd[CB] || byp_reg;
    assign idx_in_nodes = (idx_reg < GA'(NODES));

    assign stat.missed        = missed_reg;
    assign stat.head_lt_tail  = (head_reg < tail_reg);
    assign stat.sym_last      = (bsym_reg == acm_pkg::LAST_SYM);
    assign stat.idx_node_last = (idx_reg == GA'(NODES - 1));
    assign stat.idx_clr_last  = (idx_reg == GA'(GDEPTH - 1));
    assign stat.chain_stop    = stop;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        node_a = cursor_reg;
        sym_a  = sym_reg;
        if (cmd.op == acm_pkg::CMD_ROOT_RD) begin
            node_a = '0;
            sym_a  = bsym_reg;
        end else if (cmd.op == acm_pkg::CMD_E_RD) begin
            node_a = u_reg;
            sym_a  = bsym_reg;
        end
        addr_a = gaddr(node_a, sym_a);
        addr_b = gaddr(fail_rd, bsym_reg);

        goto_we    = 1'b0;
        goto_waddr = gaddr(cursor_reg, sym_reg);
        goto_wdata = nodes_used_reg[NB-1:0];
        endc_we    = 1'b0;
        endc_wdata = '0;
        pref_we    = 1'b0;
        pref_wdata = '0;
        cnt_waddr  = cursor_reg;
        fail_we    = 1'b0;
        fail_waddr = goto_rd_a;
        fail_wdata = goto_rd_b;
        queue_we   = 1'b0;
        cnt_raddr  = cursor_reg;
        fail_raddr = cursor_reg;

        case (cmd.op)
            acm_pkg::CMD_CLR_STEP:
            begin
                goto_we    = 1'b1;
                goto_waddr = idx_reg;
                goto_wdata = '0;
                endc_we    = idx_in_nodes;
                pref_we    = idx_in_nodes;
                fail_we    = idx_in_nodes;
                cnt_waddr  = idx_reg[NB-1:0];
                fail_waddr = idx_reg[NB-1:0];
                fail_wdata = '0;
            end
            acm_pkg::CMD_INS_UPD:
            begin
                goto_we   = ins_new && !full;
                cnt_raddr = nxt;
            end
            acm_pkg::CMD_INS_WR:
            begin
                pref_we    = !missed_reg;
                pref_wdata = sat_inc(pref_rd);
                endc_we    = !missed_reg && last_reg;
                endc_wdata = endc_rd[CB] ? {1'b0, CB'(1)} : {1'b0, sat_inc(endc_rd[CB-1:0])};
            end
            acm_pkg::CMD_SRCH_UPD:
            begin
                cnt_raddr = goto_rd_a;
            end
            acm_pkg::CMD_SCAN_UPD:
            begin
                cnt_raddr  = goto_rd_a;
                fail_raddr = goto_rd_a;
            end
            acm_pkg::CMD_SCAN_STEP:
            begin
                endc_we    = !stop;
                endc_wdata = {1'b1, endc_rd[CB-1:0]};
                cnt_waddr  = j_reg;
                cnt_raddr  = fail_rd;
                fail_raddr = fail_rd;
            end
            acm_pkg::CMD_FZ_STEP:
            begin
                fail_we    = 1'b1;
                fail_waddr = idx_reg[NB-1:0];
                fail_wdata = '0;
            end
            acm_pkg::CMD_ROOT_PUSH:
            begin
                queue_we = !ins_new && push_ok;
            end
            acm_pkg::CMD_F_RD:
            begin
                fail_raddr = u_reg;
            end
            acm_pkg::CMD_E_UPD:
            begin
                goto_we    = ins_new;
                goto_waddr = gaddr(u_reg, bsym_reg);
                goto_wdata = goto_rd_b;
                fail_we    = !ins_new;
                queue_we   = !ins_new && push_ok;
            end
            default:
            begin
                goto_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        goto_rd_a <= goto_mem[addr_a];
        goto_rd_b <= goto_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (endc_we) begin
            endc_mem[cnt_waddr] <= endc_wdata;
        end
        endc_rd <= endc_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pref_we) begin
            pref_mem[cnt_waddr] <= pref_wdata;
        end
        pref_rd <= pref_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rd <= fail_mem[fail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we) begin
            queue_mem[tail_reg[NB-1:0]] <= goto_rd_a;
        end
        queue_rd <= queue_mem[head_reg[NB-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_reg         <= '0;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            cursor_reg     <= '0;
            j_reg          <= '0;
            u_reg          <= '0;
            missed_reg     <= 1'b0;
            byp_reg        <= 1'b0;
            nodes_used_reg <= (NB+1)'(1);
            head_reg       <= '0;
            tail_reg       <= '0;
            total_reg      <= '0;
            bsym_reg       <= '0;
            idx_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end else begin
            rsp_valid_reg <= 1'b0;
            if (cmd.accept) begin
                op_reg   <= req.opcode;
                sym_reg  <= acm_pkg::sym_of(req.symbol);
                last_reg <= req.last;
                if (req.first && (req.opcode <= acm_pkg::OPC_SCAN)) begin
                    cursor_reg <= '0;
                    missed_reg <= 1'b0;
                    if (req.opcode == acm_pkg::OPC_SCAN) begin
                        total_reg <= '0;
                    end
                end
            end
            case (cmd.op)
                acm_pkg::CMD_CLR_START:
                begin
                    nodes_used_reg <= (NB+1)'(1);
                    cursor_reg     <= '0;
                    total_reg      <= '0;
                    missed_reg     <= 1'b0;
                    idx_reg        <= '0;
                end
                acm_pkg::CMD_CLR_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                acm_pkg::CMD_INS_UPD:
                begin
                    if (ins_new && full) begin
                        missed_reg <= 1'b1;
                    end else begin
                        if (ins_new) begin
                            nodes_used_reg <= nodes_used_reg + 1'b1;
                        end
                        cursor_reg <= nxt;
                    end
                end
                acm_pkg::CMD_INS_WR:
                begin
                    rsp_valid_reg  <= last_reg;
                    rsp_reg.count  <= '0;
                    rsp_reg.status <= missed_reg ? acm_pkg::STATUS_FULL : acm_pkg::STATUS_OK;
                end
                acm_pkg::CMD_SRCH_UPD:
                begin
                    if (!missed_reg) begin
                        if (ins_new) begin
                            missed_reg <= 1'b1;
                        end else begin
                            cursor_reg <= goto_rd_a;
                        end
                    end
                end
                acm_pkg::CMD_SRCH_RES:
                begin
                    rsp_valid_reg  <= last_reg;
                    rsp_reg.count  <= '0;
                    rsp_reg.status <= acm_pkg::STATUS_OK;
                    if (!missed_reg) begin
                        if (op_reg == acm_pkg::OPC_PREFIX) begin
                            rsp_reg.count <= sat16(pref_rd);
                        end else if (endc_rd[CB]) begin
                            rsp_reg.status <= acm_pkg::STATUS_CONSUMED;
                        end else begin
                            rsp_reg.count <= sat16(endc_rd[CB-1:0]);
                        end
                    end
                end
                acm_pkg::CMD_SCAN_UPD:
                begin
                    cursor_reg <= goto_rd_a;
                    j_reg      <= goto_rd_a;
                    byp_reg    <= 1'b0;
                end
                acm_pkg::CMD_SCAN_STEP:
                begin
                    if (!stop) begin
                        total_reg <= sat_add(total_reg, endc_rd[CB-1:0]);
                        j_reg     <= fail_rd;
                        byp_reg   <= (fail_rd == j_reg);
                    end
                end
                acm_pkg::CMD_SCAN_RES:
                begin
                    rsp_valid_reg  <= last_reg;
                    rsp_reg.count  <= sat16(total_reg);
                    rsp_reg.status <= acm_pkg::STATUS_OK;
                end
                acm_pkg::CMD_BLD_START:
                begin
                    idx_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    bsym_reg <= '0;
                end
                acm_pkg::CMD_FZ_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                acm_pkg::CMD_ROOT_PUSH, acm_pkg::CMD_E_UPD:
                begin
                    if (!ins_new && push_ok) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                    bsym_reg <= stat.sym_last ? '0 : bsym_reg + 1'b1;
                end
                acm_pkg::CMD_Q_RD:
                begin
                    if (stat.head_lt_tail) begin
                        head_reg <= head_reg + 1'b1;
                    end
                end
                acm_pkg::CMD_U_LATCH:
                begin
                    u_reg    <= queue_rd;
                    bsym_reg <= '0;
                end
                acm_pkg::CMD_DONE:
                begin
                    rsp_valid_reg  <= last_reg;
                    rsp_reg.count  <= '0;
                    rsp_reg.status <= acm_pkg::STATUS_OK;
                end
                default:
                begin
                    rsp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/aho_corasick_multi_pattern_matcher_top.sv
`default_nettype none
// Top level of the multi-pattern matcher: controller plus datapath.
// Depends on acm_pkg, acm_ctrl and acm_dp.
//
//   Channel   Handshake           Payload
//   request   start / busy        req (opcode, symbol, first, last)
//   result    rsp_valid strobe    rsp (count, status)
//
// Insert and search go through registered reads of the trie and count memories for
// each symbol; scan then also walks the failure chain node by node. Build clears
// the failure link of every node, pushes the root's children and then visits each
// queued node symbol by symbol. Reset and clear run a clearing pass over all NODES * 70
// trie entries with busy high. The result strobe lasts one cycle and cannot be held.
module aho_corasick_multi_pattern_matcher_top #(
    parameter int NODES      = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire acm_pkg::req_t req,
    output logic               busy,
    output logic               rsp_valid,
    output acm_pkg::rsp_t      rsp
);

    acm_pkg::dp_cmd_t    cmd;
    acm_pkg::dp_status_t stat;

    acm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    acm_dp #(
        .NODES      (NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

>>> tb/tb_acm_checker.sv
`timescale 1ns / 100ps
// Checker for the multi-pattern matcher: watches the request and result channels,
// predicts every result from its own trie model and compares them in order.
// Depends on acm_pkg.
module tb_acm_checker #(
    parameter int NODES      = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire acm_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire acm_pkg::rsp_t rsp,
    output int                 errors,
    output int                 pending
);
    import acm_pkg::*;

    localparam int unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

    int unsigned trie_edge[NODES * ALPHABET];
    int unsigned end_cnt[NODES];
    bit          used_up[NODES];
    int unsigned pre_cnt[NODES];
    int unsigned fail_to[NODES];
    int unsigned bfs_q[NODES];
    int unsigned node_cnt;
    int unsigned cur;
    int unsigned total;
    bit          missed;

    rsp_t        match_q[$];

    logic        smp_acc;
    logic        smp_vld;
    req_t        smp_req;
    rsp_t        smp_rsp;

    function automatic int unsigned map_byte(logic [7:0] b);
        if (b >= 8'h61 && b <= 8'h7A) return b - 8'h61;
        if (b >= 8'h41 && b <= 8'h5A) return b - 8'h41 + 26;
        if (b >= 8'h30 && b <= 8'h39) return b - 8'h30 + 52;
        return OTHER_SYM;
    endfunction

    function automatic int unsigned clip(int unsigned n);
        return (n < NODES) ? n : 0;
    endfunction

    function automatic int unsigned idx(int unsigned n, int unsigned s);
        return clip(n) * ALPHABET + (s % ALPHABET);
    endfunction

    function automatic int unsigned sat_inc(int unsigned a, int unsigned b);
        longint unsigned r;
        r = longint'(a) + longint'(b);
        return (r > CNT_MAX) ? CNT_MAX : int'(r);
    endfunction

    task automatic trie_clear();
        foreach (trie_edge[i]) trie_edge[i] = 0;
        for (int i = 0; i < NODES; i++)
        begin
            end_cnt[i] = 0;
            used_up[i] = 0;
            pre_cnt[i] = 0;
            fail_to[i] = 0;
        end
        node_cnt = 1;
        cur      = 0;
        total    = 0;
        missed   = 0;
    endtask

    task automatic link_build();
        int unsigned head;
        int unsigned tail;
        int unsigned u;
        int unsigned v;
        int unsigned via;
        head = 0;
        tail = 0;
        for (int i = 0; i < NODES; i++) fail_to[i] = 0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            v = clip(trie_edge[idx(0, i)]);
            if (v != 0 && tail < NODES)
            begin
                bfs_q[tail] = v;
                tail++;
            end
        end
        while (head < tail)
        begin
            u = clip(bfs_q[head]);
            head++;
            for (int i = 0; i < ALPHABET; i++)
            begin
                via = clip(trie_edge[idx(fail_to[u], i)]);
                if (trie_edge[idx(u, i)] != 0)
                begin
                    v = clip(trie_edge[idx(u, i)]);
                    fail_to[v] = via;
                    if (tail < NODES)
                    begin
                        bfs_q[tail] = v;
                        tail++;
                    end
                end
                else
                begin
                    trie_edge[idx(u, i)] = via;
                end
            end
        end
    endtask

    task automatic predict_match(req_t r);
        int unsigned s;
        int unsigned cnt;
        logic [1:0]  st;
        int unsigned e;
        int unsigned v;
        int unsigned j;
        rsp_t        o;
        s   = map_byte(r.symbol);
        cnt = 0;
        st  = STATUS_OK;
        if (r.opcode > OPC_CLEAR) return;
        if (r.opcode == OPC_CLEAR)
        begin
            trie_clear();
        end
        else if (r.opcode == OPC_BUILD)
        begin
            link_build();
        end
        else
        begin
            if (r.first)
            begin
                cur    = 0;
                missed = 0;
                if (r.opcode == OPC_SCAN) total = 0;
            end
            cur = clip(cur);
            if (r.opcode == OPC_INSERT)
            begin
                if (!missed)
                begin
                    e = idx(cur, s);
                    if (trie_edge[e] == 0)
                    begin
                        if (node_cnt >= NODES) missed = 1;
                        else
                        begin
                            trie_edge[e] = node_cnt;
                            node_cnt++;
                        end
                    end
                    if (!missed)
                    begin
                        cur = clip(trie_edge[e]);
                        pre_cnt[cur] = sat_inc(pre_cnt[cur], 1);
                    end
                end
                if (r.last)
                begin
                    if (missed) st = STATUS_FULL;
                    else if (used_up[cur])
                    begin
                        used_up[cur] = 0;
                        end_cnt[cur] = 1;
                    end
                    else end_cnt[cur] = sat_inc(end_cnt[cur], 1);
                end
            end
            else if (r.opcode == OPC_EXACT || r.opcode == OPC_PREFIX)
            begin
                if (!missed)
                begin
                    v = clip(trie_edge[idx(cur, s)]);
                    if (v == 0) missed = 1;
                    else cur = v;
                end
                if (r.last && !missed)
                begin
                    if (r.opcode == OPC_PREFIX) cnt = pre_cnt[cur];
                    else if (used_up[cur]) st = STATUS_CONSUMED;
                    else cnt = end_cnt[cur];
                end
            end
            else
            begin
                cur = clip(trie_edge[idx(cur, s)]);
                j = cur;
                while (j != 0 && !used_up[j])
                begin
                    total = sat_inc(total, end_cnt[j]);
                    used_up[j] = 1;
                    j = clip(fail_to[j]);
                end
                if (r.last) cnt = total;
            end
        end
        if (r.last)
        begin
            o.count  = (cnt > 16'hFFFF) ? 16'hFFFF : cnt[15:0];
            o.status = st;
            match_q.push_back(o);
        end
    endtask

    always @(negedge clk)
    begin
        smp_acc <= rst_n && start && !busy;
        smp_vld <= rst_n && rsp_valid;
        smp_req <= req;
        smp_rsp <= rsp;
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            trie_clear();
            match_q.delete();
            errors  <= 0;
            pending <= 0;
            smp_acc <= 0;
            smp_vld <= 0;
        end
        else
        begin
            if (smp_vld)
            begin
                if (match_q.size() == 0)
                begin
                    $error("unexpected result: count %0d status %0d",
                           smp_rsp.count, smp_rsp.status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = match_q.pop_front();
                    if (want.count !== smp_rsp.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, smp_rsp.count);
                        errors <= errors + 1;
                    end
                    if (want.status !== smp_rsp.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, smp_rsp.status);
                        errors <= errors + 1;
                    end
                end
            end
            if (smp_acc) predict_match(smp_req);
            pending <= match_q.size();
        end
    end
endmodule

>>> tb/tb_aho_corasick_multi_pattern_matcher_top.sv
`timescale 1ns / 100ps
// Testbench top for the multi-pattern matcher: clock, reset and request stimulus.
// Depends on acm_pkg, the matcher RTL and tb_acm_checker.
module tb_aho_corasick_multi_pattern_matcher_top;
    import acm_pkg::*;

    localparam int NODES = 1024;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic rsp_valid;
    rsp_t rsp;
    int   errors;
    int   pending;
    bit   quiet;

    logic [7:0] pat[16][4];
    int         plen[16];
    int         npat;

    aho_corasick_multi_pattern_matcher_top #(.NODES(NODES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    tb_acm_checker #(.NODES(NODES)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #200ms;
        $display("tb_aho_corasick_multi_pattern_matcher_top: FAIL");
        $finish;
    end

    task automatic send(logic [2:0] op, logic [7:0] sym, logic f, logic l);
        logic b;
        if (!quiet && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{opcode: op, symbol: sym, first: f, last: l};
        forever
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
            if (!b) break;
        end
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'h61 + $urandom_range(0, 2);
        if (r < 80) return 8'h41 + $urandom_range(0, 1);
        if (r < 88) return 8'h30 + $urandom_range(0, 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic send_word(logic [2:0] op, logic [7:0] w[], logic f, logic l);
        for (int i = 0; i < w.size(); i++)
            send(op, w[i], f && i == 0, l && i == w.size() - 1);
    endtask

    task automatic send_rand_word(logic [2:0] op, int n, logic f, logic l);
        logic [7:0] w[];
        w = new[n];
        foreach (w[i]) w[i] = rand_byte();
        send_word(op, w, f, l);
    endtask

    task automatic send_pat(logic [2:0] op, int k, int n);
        logic [7:0] w[];
        w = new[n];
        foreach (w[i]) w[i] = pat[k][i];
        send_word(op, w, 1'b1, 1'b1);
    endtask

    task automatic run_round();
        int sent;
        int r;
        int k;
        send(OPC_CLEAR, $urandom_range(0, 255), 1'b1, $urandom_range(0, 1));
        npat = $urandom_range(6, 12);
        for (int p = 0; p < npat; p++)
        begin
            plen[p] = $urandom_range(1, 4);
            for (int i = 0; i < plen[p]; i++) pat[p][i] = rand_byte();
            send_pat(OPC_INSERT, p, plen[p]);
        end
        send(OPC_BUILD, $urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
        sent = 0;
        while (sent < 110)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, npat - 1);
            if (r < 35)
            begin
                k = $urandom_range(1, 10);
                send_rand_word(OPC_SCAN, k, 1'b1, 1'b1);
                sent += k;
            end
            else if (r < 55)
            begin
                send_pat(OPC_EXACT, k, $urandom_range(1, plen[k]));
                sent += plen[k];
            end
            else if (r < 70)
            begin
                send_pat(OPC_PREFIX, k, $urandom_range(1, plen[k]));
                sent += plen[k];
            end
            else if (r < 78)
            begin
                k = $urandom_range(1, 4);
                send_rand_word(OPC_INSERT, k, 1'b1, 1'b1);
                sent += k;
            end
            else if (r < 84)
            begin
                k = $urandom_range(1, 4);
                send_rand_word($urandom_range(0, 1) ? OPC_EXACT : OPC_PREFIX, k, 1'b1, 1'b1);
                sent += k;
            end
            else if (r < 88)
            begin
                send($urandom_range(6, 7), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 1));
            end
            else if (r < 94)
            begin
                k = $urandom_range(1, 5);
                send_rand_word($urandom_range(0, 2) == 0 ? OPC_SCAN : $urandom_range(0, 2),
                               k, 1'b0, 1'b1);
                sent += k;
            end
            else
            begin
                k = $urandom_range(1, 3);
                send_rand_word($urandom_range(0, 1) ? OPC_SCAN : OPC_INSERT, k, 1'b1, 1'b0);
                sent += k;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OPC_INSERT, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_INSERT, '{8'h62}, 1'b1, 1'b1);
        send_word(OPC_INSERT, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_INSERT, '{8'h00, 8'hFF}, 1'b1, 1'b1);
        send_word(OPC_INSERT, '{8'h7A, 8'h5A, 8'h39}, 1'b1, 1'b1);
        send_word(OPC_EXACT, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_PREFIX, '{8'h61}, 1'b1, 1'b1);
        send_word(OPC_EXACT, '{8'h78}, 1'b1, 1'b1);
        send(3'd6, 8'h55, 1'b1, 1'b1);
        send(3'd7, 8'hAA, 1'b0, 1'b0);
        send(OPC_BUILD, 8'h00, 1'b0, 1'b0);
        send_word(OPC_SCAN, '{8'h78, 8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_EXACT, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_PREFIX, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send_word(OPC_INSERT, '{8'h61, 8'h62}, 1'b1, 1'b1);
        send(OPC_BUILD, 8'hFF, 1'b1, 1'b1);
        send(OPC_CLEAR, 8'h00, 1'b0, 1'b1);

        for (int i = 0; i < NODES + 1; i++)
            send(OPC_INSERT, $urandom_range(0, 255), i == 0, i == NODES);
        send_rand_word(OPC_INSERT, 2, 1'b1, 1'b1);
        send_rand_word(OPC_PREFIX, 1, 1'b1, 1'b1);

        for (int n = 0; n < 5; n++)
        begin
            quiet = (n == 2);
            run_round();
        end
        send_rand_word(OPC_EXACT, 1, 1'b1, 1'b1);
        start <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb_aho_corasick_multi_pattern_matcher_top: PASS");
        else
            $display("tb_aho_corasick_multi_pattern_matcher_top: FAIL");
        $finish;
    end
endmodule
